[design/bsfr_pkg.sv]
// Shared types, codes and the CRC step for the byte-stuffed frame receiver.
// No dependencies; used by every module of the block.
package bsfr_pkg;

	localparam logic [7:0]  FLAG_BYTE   = 8'h7E;
	localparam logic [7:0]  ESC_BYTE    = 8'h7D;
	localparam logic [7:0]  ESC_XOR     = 8'h20;
	localparam logic [15:0] CRC_POLY    = 16'h8408;
	localparam int          QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		CMD_DATA,
		CMD_CLOSE,
		CMD_NOSTART
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  data;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOSTART = 2'd1,
		ST_SHORT   = 2'd2,
		ST_CRC     = 2'd3
	} status_t;

	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

[design/bsfr_front.sv]
// Front end: tracks delimiter and escape state and turns raw bytes into commands.
// Depends on bsfr_pkg.
module bsfr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [7:0]          in_byte,
	input  logic                in_ready,
	output logic                push,
	output bsfr_pkg::cmd_t      cmd
);

	typedef enum logic [1:0] {
		WAIT_FLAG,
		READ_MSG,
		READ_ESC
	} mode_t;

	mode_t mode_q;
	logic  accept;

	assign accept = in_valid && in_ready;

	always_comb begin
		push      = 1'b0;
		cmd.kind  = bsfr_pkg::CMD_DATA;
		cmd.data  = in_byte;
		case (mode_q)
			READ_MSG: begin
				if (in_byte == bsfr_pkg::FLAG_BYTE) begin
					push     = accept;
					cmd.kind = bsfr_pkg::CMD_CLOSE;
				end else if (in_byte != bsfr_pkg::ESC_BYTE) begin
					push = accept;
				end
			end
			READ_ESC: begin
				push     = accept;
				cmd.data = in_byte ^ bsfr_pkg::ESC_XOR;
			end
			default: begin
				if (in_byte != bsfr_pkg::FLAG_BYTE) begin
					push     = accept;
					cmd.kind = bsfr_pkg::CMD_NOSTART;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= WAIT_FLAG;
		end else if (accept) begin
			case (mode_q)
				READ_MSG: begin
					if (in_byte == bsfr_pkg::FLAG_BYTE) begin
						mode_q <= WAIT_FLAG;
					end else if (in_byte == bsfr_pkg::ESC_BYTE) begin
						mode_q <= READ_ESC;
					end
				end
				READ_ESC: begin
					mode_q <= READ_MSG;
				end
				default: begin
					if (in_byte == bsfr_pkg::FLAG_BYTE) begin
						mode_q <= READ_MSG;
					end
				end
			endcase
		end
	end

endmodule

[design/bsfr_queue.sv]
// Short command queue between front and back ends.
// Depends on bsfr_pkg.
module bsfr_queue #(
	parameter int DEPTH = bsfr_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bsfr_pkg::cmd_t  push_cmd,
	output logic            push_ready,
	input  logic            pop,
	output logic            pop_valid,
	output bsfr_pkg::cmd_t  pop_cmd
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bsfr_pkg::cmd_t    mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (cnt_q != CNT_W'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[design/bsfr_back.sv]
// Back end: CRC, decoded-byte count, two-byte hold and the result register.
// Depends on bsfr_pkg.
module bsfr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	input  bsfr_pkg::cmd_t  cmd,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            out_kind,
	output logic [7:0]      out_byte,
	output logic [1:0]      out_status,
	output logic            out_last
);

	logic [15:0] crc_q;
	logic [1:0]  count_q;
	logic [7:0]  held_q [2];
	logic        out_valid_q;
	logic        out_kind_q;
	logic [7:0]  out_byte_q;
	logic [1:0]  out_status_q;
	logic        out_last_q;

	logic        is_data;
	logic        emit;
	logic [1:0]  status;

	assign pop     = cmd_valid && (!out_valid_q || out_ready);
	assign is_data = (cmd.kind == bsfr_pkg::CMD_DATA);
	assign emit    = !is_data || (count_q >= 2'd2);

	always_comb begin
		case (cmd.kind)
			bsfr_pkg::CMD_CLOSE: begin
				if (count_q != 2'd3) begin
					status = bsfr_pkg::ST_SHORT;
				end else if (crc_q != 16'h0000) begin
					status = bsfr_pkg::ST_CRC;
				end else begin
					status = bsfr_pkg::ST_OK;
				end
			end
			bsfr_pkg::CMD_NOSTART: begin
				status = bsfr_pkg::ST_NOSTART;
			end
			default: begin
				status = bsfr_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop && is_data) begin
			if (count_q >= 2'd2) begin
				held_q[0] <= held_q[1];
				held_q[1] <= cmd.data;
			end else if (count_q[0]) begin
				held_q[1] <= cmd.data;
			end else begin
				held_q[0] <= cmd.data;
			end
		end
		if (pop && emit) begin
			out_kind_q   <= !is_data;
			out_byte_q   <= is_data ? held_q[0] : 8'h00;
			out_status_q <= status;
			out_last_q   <= !is_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (is_data) begin
					crc_q <= bsfr_pkg::crc_step(crc_q, cmd.data);
					if (count_q != 2'd3) begin
						count_q <= count_q + 2'd1;
					end
				end else begin
					crc_q   <= '0;
					count_q <= '0;
				end
			end
			if (pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_kind   = out_kind_q;
	assign out_byte   = out_byte_q;
	assign out_status = out_status_q;
	assign out_last   = out_last_q;

	a_report_clears: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !is_data |=> count_q == 2'd0 && crc_q == 16'h0000)
		else $error("frame state not cleared after report");

	a_payload_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pop && is_data && count_q >= 2'd2 |=> out_valid_q && !out_kind_q && count_q == 2'd3)
		else $error("payload emitted without full hold");

	a_short_frame: assert property (@(posedge clk) disable iff (!arst_n)
		pop && cmd.kind == bsfr_pkg::CMD_CLOSE && count_q != 2'd3
		|=> out_valid_q && out_status_q == bsfr_pkg::ST_SHORT)
		else $error("short frame not reported");

endmodule

[design/byte_stuffed_frame_receiver_crc16_core.sv]
// Top level of the byte-stuffed frame receiver with CRC-16 check.
// Depends on bsfr_pkg, bsfr_front, bsfr_queue and bsfr_back.
//
//   channel  dir  handshake            payload
//   s_*      in   s_tvalid/s_tready    tdata[7:0] rx_byte
//   m_*      out  m_tvalid/m_tready    tdata[7:0] payload_byte, [9:8] frame_status,
//                                      tuser[0] out_kind, tlast frame_last
//
// One byte per cycle unless output stalls; a result registers as its emitting command pops.
// The CRC update in the back end, one byte per cycle, sets the rate.
// Reset clears delimiter state, CRC, count, queue and the output valid.
// A stalled output holds the back end; the queue then fills and drops s_tready.
module byte_stuffed_frame_receiver_crc16_core #(
	parameter int QUEUE_DEPTH = bsfr_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] payload_byte, [9:8] frame_status, [15:10] zero
	output logic        m_tlast,
	output logic [0:0]  m_tuser    // [0] out_kind
);

	logic            push;
	bsfr_pkg::cmd_t  push_cmd;
	logic            pop;
	logic            pop_valid;
	bsfr_pkg::cmd_t  pop_cmd;
	logic            out_kind;
	logic [7:0]      out_byte;
	logic [1:0]      out_status;

	bsfr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_byte  (s_tdata),
		.in_ready (s_tready),
		.push     (push),
		.cmd      (push_cmd)
	);

	bsfr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.push_ready (s_tready),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_cmd    (pop_cmd)
	);

	bsfr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (pop_valid),
		.cmd        (pop_cmd),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_kind   (out_kind),
		.out_byte   (out_byte),
		.out_status (out_status),
		.out_last   (m_tlast)
	);

	assign m_tdata = {6'b000000, out_status, out_byte};
	assign m_tuser = out_kind;

endmodule
